@@ src/ibt_pkg.sv @@
// Shared constants, types and status codes for the interval booking table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ibt_pkg;

    localparam int CAPACITY   = 1024;
    localparam int TIME_WIDTH = 32;

    localparam int IN_TIME_W  = 32;
    localparam int ENTRIES_W  = 11;

    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] lo;
        logic [TIME_WIDTH-1:0] hi;
        logic                  invalid;
    } t_req;

endpackage

@@ src/ibt_front.sv @@
// Front end of the interval booking table: takes request items and classifies them.
// Depends on ibt_pkg; feeds the request queue (ibt_fifo).
`timescale 1ns / 1ps

module ibt_front
    import ibt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IN_TIME_W-1:0] i_start_time,
    input  logic [IN_TIME_W-1:0] i_end_time,
    input  logic                 i_full,
    output logic                 o_push,
    output t_req                 o_req
);

    logic [TIME_WIDTH-1:0] w_lo;
    logic [TIME_WIDTH-1:0] w_hi;

    assign w_lo       = TIME_WIDTH'(i_start_time);
    assign w_hi       = TIME_WIDTH'(i_end_time);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // flag empty or reversed intervals up front
    assign o_req.lo      = w_lo;
    assign o_req.hi      = w_hi;
    assign o_req.invalid = (w_lo >= w_hi);

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push while queue full");
    a_invalid_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (w_lo < w_hi)) |-> !o_req.invalid)
        else $error("well-formed interval flagged invalid");
    a_ready_tracks_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> o_push)
        else $error("accepted item not pushed");
`endif

endmodule

@@ src/ibt_fifo.sv @@
// Short request queue between the front end and the scan engine of the booking table.
// Depends on ibt_pkg for the request type and depth.
`timescale 1ns / 1ps

module ibt_fifo
    import ibt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_valid,
    output t_req o_req,
    input  logic i_pop
);

    t_req               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_cnt;

    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd_ptr];

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not grow on push");
`endif

endmodule

@@ src/ibt_back.sv @@
// Scan engine of the booking table: checks a well-formed request on a non-full table
// against the stored intervals, appends it when free, and holds the result register.
// Depends on ibt_pkg; takes requests from ibt_fifo.
`timescale 1ns / 1ps

module ibt_back
    import ibt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  t_req                 i_req,
    output logic                 o_req_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_accepted,
    output logic [1:0]           o_status,
    output logic [ENTRIES_W-1:0] o_entries_used
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    logic [TIME_WIDTH-1:0] r_mem_lo [CAPACITY];
    logic [TIME_WIDTH-1:0] r_mem_hi [CAPACITY];
    logic [TIME_WIDTH-1:0] r_rd_lo;
    logic [TIME_WIDTH-1:0] r_rd_hi;

    t_state                r_state,     n_state;
    logic [CNT_W-1:0]      r_count,     n_count;
    logic [IDX_W-1:0]      r_idx,       n_idx;
    logic                  r_pend,      n_pend;
    logic [TIME_WIDTH-1:0] r_lo,        n_lo;
    logic [TIME_WIDTH-1:0] r_hi,        n_hi;
    t_status               r_status,    n_status;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_stat,  n_out_stat;
    logic [CNT_W-1:0]      r_out_cnt,   n_out_cnt;

    logic                  w_at_count;
    logic                  w_rd_en;
    logic                  w_hit;
    logic                  w_out_free;
    logic                  w_commit;
    logic                  w_wr_en;

    assign w_at_count = ({1'b0, r_idx} == (IDX_W + 1)'(r_count));
    assign w_rd_en    = (r_state == S_SCAN) && !w_at_count;
    assign w_hit      = r_pend && (r_lo < r_rd_hi) && (r_hi > r_rd_lo);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_DONE) && w_out_free;
    assign w_wr_en    = w_commit && (r_status == ST_BOOKED);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_lo[r_count[IDX_W-1:0]] <= r_lo;
            r_mem_hi[r_count[IDX_W-1:0]] <= r_hi;
        end
        if (w_rd_en) begin
            r_rd_lo <= r_mem_lo[r_idx];
            r_rd_hi <= r_mem_hi[r_idx];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        o_req_pop   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_lo      = i_req.lo;
                    n_hi      = i_req.hi;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    if (i_req.invalid) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = w_rd_en;
                if (w_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_hit) begin
                    n_status = ST_OVERLAP;
                    n_state  = S_DONE;
                end else if (!r_pend && w_at_count) begin
                    n_status = ST_BOOKED;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = r_status;
                    if (r_status == ST_BOOKED) begin
                        n_count   = r_count + 1'b1;
                        n_out_cnt = r_count + 1'b1;
                    end else begin
                        n_out_cnt = r_count;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_status   <= n_status;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = (r_out_stat == ST_BOOKED);
    assign o_status       = r_out_stat;
    assign o_entries_used = ENTRIES_W'(r_out_cnt);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} <= (IDX_W + 1)'(r_count)))
        else $error("scan index past entry count");
    a_scan_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != CNT_W'(CAPACITY)))
        else $error("scan started on a full table");
    a_book_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count == $past(r_count) + 1'b1) && (r_out_cnt == r_count))
        else $error("booking did not advance entry count");
    a_hit_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_hit) |=> (r_status == ST_OVERLAP))
        else $error("conflict not reported as overlap");
`endif

endmodule

@@ src/interval_booking_table.sv @@
// Top level of the interval booking table: front end, request queue, scan engine.
// Depends on ibt_pkg, ibt_front, ibt_fifo and ibt_back.
`timescale 1ns / 1ps

// Each request item carries a half-open interval [start, end) and returns one
// result item: accepted, a status code (booked, overlaps a stored interval,
// table full, start not below end) and the number of stored intervals after
// the request. A booked interval is appended to an internal table of up to
// 1024 entries; no entry is ever removed. Empty or reversed intervals and
// requests on a full table skip the scan and go from the request queue
// straight to the done state of the scan engine. Any other request is
// compared against the stored intervals one per cycle, reading one table
// entry per cycle from the interval memory, and the scan ends early when an
// overlap is found. A two-entry request queue lets new items be taken while
// a scan runs, and the result register lets the next scan start while a
// result waits.
module interval_booking_table
    import ibt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IN_TIME_W-1:0] i_start_time,
    input  logic [IN_TIME_W-1:0] i_end_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_accepted,
    output logic [1:0]           o_status,
    output logic [ENTRIES_W-1:0] o_entries_used
);

    logic w_push;
    t_req w_push_req;
    logic w_full;
    logic w_q_valid;
    t_req w_q_req;
    logic w_pop;

    ibt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_time (i_start_time),
        .i_end_time   (i_end_time),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_req        (w_push_req)
    );

    ibt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_req   (w_q_req),
        .i_pop   (w_pop)
    );

    ibt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (w_q_valid),
        .i_req          (w_q_req),
        .o_req_pop      (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_accepted     (o_accepted),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

endmodule
